@@ rtl/gclp_pkg.sv @@
package gclp_pkg;

	// Character codes the parser reacts to.
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_G     = 8'h47;
	localparam logic [7:0] CH_M     = 8'h4D;
	localparam logic [7:0] CH_X     = 8'h58;
	localparam logic [7:0] CH_Y     = 8'h59;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_E     = 8'h45;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_T     = 8'h54;

	localparam int AXIS_COUNT = 6;

	// Axis slots; AXIS_NONE marks a character that names no axis.
	localparam logic [2:0] AXIS_X    = 3'd0;
	localparam logic [2:0] AXIS_Y    = 3'd1;
	localparam logic [2:0] AXIS_Z    = 3'd2;
	localparam logic [2:0] AXIS_E    = 3'd3;
	localparam logic [2:0] AXIS_F    = 3'd4;
	localparam logic [2:0] AXIS_T    = 3'd5;
	localparam logic [2:0] AXIS_NONE = 3'd6;

	// Command number saturation limits.
	localparam logic [15:0] NUM_CAP     = 16'h8000;
	localparam logic [15:0] NUM_POS_MAX = 16'h7FFF;

	typedef enum logic [1:0] {
		NUM_SKIP,
		NUM_DIGITS,
		NUM_DONE
	} gclp_num_phase_t;

	typedef enum logic [1:0] {
		VAL_SIGN,
		VAL_INT,
		VAL_FRAC,
		VAL_DONE
	} gclp_val_phase_t;

	// Control from the line sequencer to the axis unit.
	typedef struct packed {
		logic feed;    // a character inside an accepted command line
		logic finish;  // the line ends; present the fields and clear
	} gclp_axis_ctl_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_skip_ws(input logic [7:0] c, input logic allow_space);
		return (allow_space && (c == CH_SPACE)) || (c == CH_TAB) || (c == CH_VT) ||
			(c == CH_FF);
	endfunction

	function automatic logic [2:0] axis_index(input logic [7:0] c);
		logic [2:0] idx;
		case (c)
			CH_X: idx = AXIS_X;
			CH_Y: idx = AXIS_Y;
			CH_Z: idx = AXIS_Z;
			CH_E: idx = AXIS_E;
			CH_F: idx = AXIS_F;
			CH_T: idx = AXIS_T;
			default: idx = AXIS_NONE;
		endcase
		return idx;
	endfunction

	// Powers of ten for the fixed point scaling, 10^0 up to 10^6.
	function automatic logic [19:0] pow10(input logic [2:0] k);
		logic [19:0] p;
		case (k)
			3'd0: p = 20'd1;
			3'd1: p = 20'd10;
			3'd2: p = 20'd100;
			3'd3: p = 20'd1000;
			3'd4: p = 20'd10000;
			3'd5: p = 20'd100000;
			3'd6: p = 20'd1000000;
			default: p = 20'd0;
		endcase
		return p;
	endfunction

endpackage

@@ rtl/gclp_char_if.sv @@
interface gclp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface

@@ rtl/gclp_result_if.sv @@
interface gclp_result_if #(
	parameter int VALUE_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic                          is_command;
	logic [7:0]                    command_letter;
	logic signed [15:0]            command_number;
	logic [5:0]                    present_mask;
	logic signed [VALUE_WIDTH-1:0] value_x;
	logic signed [VALUE_WIDTH-1:0] value_y;
	logic signed [VALUE_WIDTH-1:0] value_z;
	logic signed [VALUE_WIDTH-1:0] value_e;
	logic signed [VALUE_WIDTH-1:0] value_f;
	logic signed [VALUE_WIDTH-1:0] value_t;

	modport source (output valid, output is_command, output command_letter,
		output command_number, output present_mask, output value_x, output value_y,
		output value_z, output value_e, output value_f, output value_t, input ready);
	modport sink (input valid, input is_command, input command_letter,
		input command_number, input present_mask, input value_x, input value_y,
		input value_z, input value_e, input value_f, input value_t, output ready);
endinterface

@@ rtl/gcode_line_field_parser.sv @@
// G-code line field parser. Characters arrive one word at a time on char_stream;
// a newline or carriage return closes the line, and every non-empty line yields
// exactly one word on line_result, while empty lines yield nothing. A line that
// starts with G or M is reported as a command with its letter, the signed command
// number after the letter (saturated to 16 bits), and the X, Y, Z, E, F and T
// values in fixed point with FRAC_DIGITS fraction digits, saturated to
// VALUE_WIDTH signed bits; any other line reports all fields zero. The block
// takes one character per clock unless stalled: each word is registered, then
// all parsing for it is one multiply-by-ten accumulate and state update, and a
// line result is registered as its terminating character leaves the input
// register. Back pressure on line_result stalls char_stream only when a line
// end reaches the input register while the previous result waits to be taken.
module gcode_line_field_parser #(
	parameter int FRAC_DIGITS = 3,
	parameter int VALUE_WIDTH = 32
) (
	input logic            clk,
	input logic            arst_n,
	gclp_char_if.sink      char_stream,
	gclp_result_if.source  line_result
);
	import gclp_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Line state.
	logic            started_q;
	logic            rejected_q;
	logic [7:0]      letter_q;
	logic [15:0]     num_q;
	logic            num_neg_q;
	gclp_num_phase_t num_ph_q;

	// Result register.
	logic                   res_valid_q;
	logic                   res_cmd_q;
	logic [7:0]             res_letter_q;
	logic [15:0]            res_number_q;
	logic [5:0]             res_mask_q;
	logic [AXIS_COUNT-1:0][VALUE_WIDTH-1:0] res_values_q;

	logic                   is_eol;
	logic                   emit;
	logic                   advance;
	gclp_axis_ctl_t         axis_ctl;
	logic [AXIS_COUNT-1:0][VALUE_WIDTH-1:0] axis_values;
	logic [AXIS_COUNT-1:0]  axis_present;
	logic [19:0]            num_ext;
	logic [19:0]            num_sum;
	logic [15:0]            num_sat;
	logic [15:0]            num_out;

	assign is_eol  = (char_s1 == CH_LF) || (char_s1 == CH_CR);
	assign emit    = is_eol && started_q;
	// The registered character moves on unless it would produce a result
	// while the previous one is still waiting to be taken.
	assign advance = valid_s1 && (!emit || !res_valid_q || line_result.ready);
	assign char_stream.ready = !valid_s1 || advance;

	assign axis_ctl.finish = advance && emit;
	assign axis_ctl.feed   = advance && !is_eol && started_q && !rejected_q;

	gclp_axis_unit #(
		.FRAC_DIGITS (FRAC_DIGITS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_axis (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (axis_ctl),
		.char_code    (char_s1),
		.axis_values  (axis_values),
		.present_mask (axis_present)
	);

	// Command number: multiply-by-ten accumulate saturating at 32768.
	assign num_ext = {4'b0, num_q};
	assign num_sum = (num_ext << 3) + (num_ext << 1) + 20'(char_s1[3:0]);
	assign num_sat = (num_sum >= 20'(NUM_CAP)) ? NUM_CAP : num_sum[15:0];
	assign num_out = num_neg_q ? (~num_q + 1'b1) :
		((num_q > NUM_POS_MAX) ? NUM_POS_MAX : num_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_stream.ready) begin
			valid_s1 <= char_stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_stream.ready && char_stream.valid) begin
			char_s1 <= char_stream.char_code;
		end
	end

	// Line sequencing: first character decides command or not, the rest feed
	// the command number and the axis tokenizer. Everything clears at the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			rejected_q <= 1'b0;
			letter_q   <= '0;
			num_q      <= '0;
			num_neg_q  <= 1'b0;
			num_ph_q   <= NUM_SKIP;
		end else if (advance) begin
			if (is_eol) begin
				started_q  <= 1'b0;
				rejected_q <= 1'b0;
				letter_q   <= '0;
				num_q      <= '0;
				num_neg_q  <= 1'b0;
				num_ph_q   <= NUM_SKIP;
			end else if (!started_q) begin
				started_q <= 1'b1;
				if ((char_s1 == CH_G) || (char_s1 == CH_M)) begin
					letter_q <= char_s1;
				end else begin
					rejected_q <= 1'b1;
				end
			end else if (!rejected_q) begin
				case (num_ph_q)
					NUM_SKIP: begin
						if (!is_skip_ws(char_s1, 1'b1)) begin
							if ((char_s1 == CH_PLUS) || (char_s1 == CH_MINUS)) begin
								num_ph_q  <= NUM_DIGITS;
								num_neg_q <= (char_s1 == CH_MINUS);
							end else if (is_digit(char_s1)) begin
								num_ph_q <= NUM_DIGITS;
								num_q    <= num_sat;
							end else begin
								num_ph_q <= NUM_DONE;
							end
						end
					end
					NUM_DIGITS: begin
						if (is_digit(char_s1)) begin
							num_q <= num_sat;
						end else begin
							num_ph_q <= NUM_DONE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (line_result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// A line that did not start with G or M reports every field as zero.
	always_ff @(posedge clk) begin
		if (advance && emit) begin
			if (rejected_q) begin
				res_cmd_q    <= 1'b0;
				res_letter_q <= '0;
				res_number_q <= '0;
				res_mask_q   <= '0;
				res_values_q <= '0;
			end else begin
				res_cmd_q    <= 1'b1;
				res_letter_q <= letter_q;
				res_number_q <= num_out;
				res_mask_q   <= axis_present;
				res_values_q <= axis_values;
			end
		end
	end

	assign line_result.valid          = res_valid_q;
	assign line_result.is_command     = res_cmd_q;
	assign line_result.command_letter = res_letter_q;
	assign line_result.command_number = res_number_q;
	assign line_result.present_mask   = res_mask_q;
	assign line_result.value_x        = res_values_q[AXIS_X];
	assign line_result.value_y        = res_values_q[AXIS_Y];
	assign line_result.value_z        = res_values_q[AXIS_Z];
	assign line_result.value_e        = res_values_q[AXIS_E];
	assign line_result.value_f        = res_values_q[AXIS_F];
	assign line_result.value_t        = res_values_q[AXIS_T];

endmodule

@@ rtl/gclp_axis_unit.sv @@
module gclp_axis_unit #(
	parameter int FRAC_DIGITS = 3,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                                                clk,
	input  logic                                                arst_n,
	input  gclp_pkg::gclp_axis_ctl_t                            ctl,
	input  logic [7:0]                                          char_code,
	output logic [gclp_pkg::AXIS_COUNT-1:0][VALUE_WIDTH-1:0]    axis_values,
	output logic [gclp_pkg::AXIS_COUNT-1:0]                     present_mask
);
	import gclp_pkg::*;

	localparam int FracW = $clog2(FRAC_DIGITS + 1);
	localparam int ExtW  = VALUE_WIDTH + 24;
	localparam logic [VALUE_WIDTH-1:0] Cap   = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
	localparam logic [VALUE_WIDTH-1:0] CapM1 = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
	localparam logic [ExtW-1:0]        CapExt = {{(ExtW-VALUE_WIDTH){1'b0}}, Cap};

	// The accumulator already holds the magnitude scaled to the full fraction
	// width, saturated at Cap, so committing a token needs no further scaling.
	logic                              tok_value_q, tok_value_d;
	logic [7:0]                        axis_char_q, axis_char_d;
	logic [VALUE_WIDTH-1:0]            scaled_q, scaled_d;
	logic                              neg_q, neg_d;
	gclp_val_phase_t                   vph_q, vph_d;
	logic [FracW-1:0]                  frac_cnt_q, frac_cnt_d;
	logic [AXIS_COUNT-1:0][VALUE_WIDTH-1:0] axis_q, axis_d;
	logic [AXIS_COUNT-1:0]             present_q, present_d;

	logic [3:0]             digit;
	logic [ExtW-1:0]        scaled_ext;
	logic [23:0]            int_inc;
	logic [23:0]            frac_inc;
	logic [ExtW-1:0]        int_sum;
	logic [ExtW-1:0]        frac_sum;
	logic [VALUE_WIDTH-1:0] int_sat;
	logic [VALUE_WIDTH-1:0] frac_sat;
	logic [2:0]             frac_pow_idx;
	logic [VALUE_WIDTH-1:0] commit_value;
	logic [2:0]             commit_idx;
	logic                   commit_now;

	assign digit        = char_code[3:0];
	assign scaled_ext   = {{(ExtW-VALUE_WIDTH){1'b0}}, scaled_q};
	assign frac_pow_idx = 3'(FRAC_DIGITS - 1) - 3'(frac_cnt_q);
	assign int_inc      = 24'(digit) * 24'(pow10(3'(FRAC_DIGITS)));
	assign frac_inc     = 24'(digit) * 24'(pow10(frac_pow_idx));
	assign int_sum      = (scaled_ext << 3) + (scaled_ext << 1) + ExtW'(int_inc);
	assign frac_sum     = scaled_ext + ExtW'(frac_inc);
	assign int_sat      = (int_sum >= CapExt) ? Cap : int_sum[VALUE_WIDTH-1:0];
	assign frac_sat     = (frac_sum >= CapExt) ? Cap : frac_sum[VALUE_WIDTH-1:0];

	assign commit_idx   = axis_index(axis_char_q);
	assign commit_value = neg_q ? (~scaled_q + 1'b1) :
		((scaled_q > CapM1) ? CapM1 : scaled_q);

	always_comb begin : next_state
		gclp_val_phase_t ph;
		logic            consumed;
		ph          = vph_q;
		consumed    = 1'b0;
		tok_value_d = tok_value_q;
		axis_char_d = axis_char_q;
		scaled_d    = scaled_q;
		neg_d       = neg_q;
		vph_d       = vph_q;
		frac_cnt_d  = frac_cnt_q;
		axis_d      = axis_q;
		present_d   = present_q;
		commit_now  = 1'b0;
		if (ctl.finish) begin
			tok_value_d = 1'b0;
			axis_char_d = '0;
			scaled_d    = '0;
			neg_d       = 1'b0;
			vph_d       = VAL_SIGN;
			frac_cnt_d  = '0;
			axis_d      = '0;
			present_d   = '0;
		end else if (ctl.feed) begin
			if (!tok_value_q) begin
				tok_value_d = 1'b1;
				axis_char_d = char_code;
				scaled_d    = '0;
				neg_d       = 1'b0;
				vph_d       = VAL_SIGN;
				frac_cnt_d  = '0;
			end else if (char_code == CH_SPACE) begin
				tok_value_d = 1'b0;
				commit_now  = 1'b1;
			end else begin
				if (ph == VAL_SIGN) begin
					if (is_skip_ws(char_code, 1'b0)) begin
						consumed = 1'b1;
					end else begin
						ph = VAL_INT;
						if ((char_code == CH_PLUS) || (char_code == CH_MINUS)) begin
							neg_d    = (char_code == CH_MINUS);
							consumed = 1'b1;
						end
					end
				end
				if (!consumed) begin
					case (ph)
						VAL_INT: begin
							if (is_digit(char_code)) begin
								scaled_d = int_sat;
							end else if (char_code == CH_DOT) begin
								ph = VAL_FRAC;
							end else begin
								ph = VAL_DONE;
							end
						end
						VAL_FRAC: begin
							if (is_digit(char_code)) begin
								if (frac_cnt_q < FracW'(FRAC_DIGITS)) begin
									scaled_d   = frac_sat;
									frac_cnt_d = frac_cnt_q + 1'b1;
								end
							end else begin
								ph = VAL_DONE;
							end
						end
						default: begin
						end
					endcase
				end
				vph_d = ph;
			end
		end
		if (commit_now) begin
			for (int i = 0; i < AXIS_COUNT; i++) begin
				if (commit_idx == 3'(i)) begin
					axis_d[i]    = commit_value;
					present_d[i] = 1'b1;
				end
			end
		end
	end

	// Fields of the finished line: an open token is folded in at the line end.
	always_comb begin
		axis_values  = axis_q;
		present_mask = present_q;
		for (int i = 0; i < AXIS_COUNT; i++) begin
			if (tok_value_q && (commit_idx == 3'(i))) begin
				axis_values[i]  = commit_value;
				present_mask[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_value_q <= 1'b0;
			axis_char_q <= '0;
			scaled_q    <= '0;
			neg_q       <= 1'b0;
			vph_q       <= VAL_SIGN;
			frac_cnt_q  <= '0;
			axis_q      <= '0;
			present_q   <= '0;
		end else begin
			tok_value_q <= tok_value_d;
			axis_char_q <= axis_char_d;
			scaled_q    <= scaled_d;
			neg_q       <= neg_d;
			vph_q       <= vph_d;
			frac_cnt_q  <= frac_cnt_d;
			axis_q      <= axis_d;
			present_q   <= present_d;
		end
	end

endmodule
